/* rtl/ldlt_pkg.sv */
package ldlt_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 4;
  localparam int WIDX_W      = $clog2(MAX_ORDER);
  localparam int NUM_W       = DATA_W + FRAC_W;
  localparam int CNT_W       = $clog2(NUM_W + 1);

  // datapath operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LDA     = 3'd1;
  localparam logic [2:0] OP_MUL_RA  = 3'd2;
  localparam logic [2:0] OP_MUL_RW  = 3'd3;
  localparam logic [2:0] OP_WSET    = 3'd4;
  localparam logic [2:0] OP_ACC_LD  = 3'd5;
  localparam logic [2:0] OP_ACC_SUB = 3'd6;
  localparam logic [2:0] OP_D_LD    = 3'd7;

  // store write sources
  localparam logic [1:0] WR_IN   = 2'd0;
  localparam logic [1:0] WR_ACC  = 2'd1;
  localparam logic [1:0] WR_ZERO = 2'd2;
  localparam logic [1:0] WR_DIV  = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [WIDX_W-1:0] widx;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [1:0]        wr_src;
    logic              flag_clr;
    logic              zp_set;
    logic              div_start;
  } ldlt_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic div_done;
  } ldlt_stat_t;

  // packed column-major position of (row, col), row >= col
  function automatic logic [ADDR_W-1:0] pidx(input logic [IDX_W-1:0] n,
                                             input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
    logic [7:0] span;
    logic [7:0] prod;
    logic [7:0] pos;
    span = {3'b0, n, 1'b0} - {4'b0, col} - 8'd1;
    prod = 8'({4'b0, col} * span);
    pos  = 8'((prod >> 1) + {4'b0, row});
    return pos[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/packed_ldlt_decomposition.sv */
// Loading: one element per cycle, start is taken whenever busy is low.
// After the last element the block is busy factorizing: per column j, a column
// step, j w products, then per row a load, j multiply-subtracts and a store, plus
// an off-diagonal quotient (bit-serial, one bit a cycle); the divider dominates.
// Results then stream one per cycle, n(n+1)/2 of them; the receiver cannot stall.
// Synchronous active-low reset: idle, order 8, load count and flags cleared.
module packed_ldlt_decomposition import ldlt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_wdata,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [ADDR_W-1:0]        out_packed_index,
  output logic                     out_is_last,
  output logic                     out_zero_pivot,
  output logic                     out_saturated
);

  ldlt_cmd_t         cmd;
  ldlt_stat_t        stat;
  logic [DATA_W-1:0] rd_data;

  ldlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .cmd        (cmd),
    .out_strobe (out_strobe),
    .out_index  (out_packed_index),
    .out_last   (out_is_last)
  );

  ldlt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_element_value),
    .stat     (stat),
    .rd_data  (rd_data),
    .zp_flag  (out_zero_pivot),
    .sat_flag (out_saturated)
  );

  assign out_result_value = rd_data;

endmodule

/* rtl/ldlt_ram.sv */
module ldlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ldlt_div.sv */
module ldlt_div import ldlt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output logic [DATA_W-1:0]        quo,
  output logic                     ovf
);

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [NUM_W-1:0]  lim;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num[NUM_W-1] ? NUM_W'(-num) : num;
      den_nxt  = den[DATA_W-1] ? DATA_W'(-den) : den;
      neg_nxt  = num[NUM_W-1] ^ den[DATA_W-1];
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DATA_W'(rem_sh - {1'b0, den_r}) : rem_sh[DATA_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // negative side reaches one further
  assign lim  = neg_r ? (NUM_W'(1) << (DATA_W - 1)) : ((NUM_W'(1) << (DATA_W - 1)) - 1'b1);
  assign ovf  = quo_r > lim;
  assign quo  = ovf ? (neg_r ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}})
                    : (neg_r ? DATA_W'(-quo_r[DATA_W-1:0]) : quo_r[DATA_W-1:0]);
  assign done = done_r;

endmodule

/* rtl/ldlt_dp.sv */
module ldlt_dp import ldlt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ldlt_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] in_data,
  output ldlt_stat_t               stat,
  output logic [DATA_W-1:0]        rd_data,
  output logic                     zp_flag,
  output logic                     sat_flag
);

  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0]   a_r, acc_r, d_r;
  logic signed [2*DATA_W-1:0] p_r;
  logic signed [DATA_W-1:0]   w_r [MAX_ORDER];
  logic                       zp_r, sat_r;
  logic signed [DATA_W-1:0]   rdv;
  logic signed [2*DATA_W-FRAC_W-1:0] sh;
  logic signed [DATA_W-1:0]   msat;
  logic                       mov;
  logic signed [DATA_W:0]     diff;
  logic signed [DATA_W-1:0]   dsat;
  logic                       dov;
  logic [DATA_W-1:0]          wdata;
  logic                       div_done, div_ovf;
  logic [DATA_W-1:0]          div_quo;

  assign rdv = rd_data;

  // product scaled back, rounding toward minus infinity
  assign sh   = p_r[2*DATA_W-1:FRAC_W];
  assign mov  = (sh[2*DATA_W-FRAC_W-1:DATA_W-1] != '0) && (sh[2*DATA_W-FRAC_W-1:DATA_W-1] != '1);
  assign msat = mov ? (sh[2*DATA_W-FRAC_W-1] ? VMIN : VMAX) : sh[DATA_W-1:0];

  assign diff = {acc_r[DATA_W-1], acc_r} - {msat[DATA_W-1], msat};
  assign dov  = diff[DATA_W] != diff[DATA_W-1];
  assign dsat = dov ? (diff[DATA_W] ? VMIN : VMAX) : diff[DATA_W-1:0];

  always_comb begin
    case (cmd.wr_src)
      WR_IN:   wdata = in_data;
      WR_ACC:  wdata = acc_r;
      WR_ZERO: wdata = '0;
      WR_DIV:  wdata = div_quo;
      default: wdata = '0;
    endcase
  end

  ldlt_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  ldlt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ({acc_r, {FRAC_W{1'b0}}}),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LDA:     a_r <= rdv;
      OP_MUL_RA:  p_r <= a_r * rdv;
      OP_MUL_RW:  p_r <= rdv * w_r[cmd.widx];
      OP_WSET:    w_r[cmd.widx] <= msat;
      OP_ACC_LD:  acc_r <= rdv;
      OP_ACC_SUB: acc_r <= dsat;
      OP_D_LD:    d_r <= acc_r;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r  <= 1'b0;
      sat_r <= 1'b0;
    end else if (cmd.flag_clr) begin
      zp_r  <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.zp_set && acc_r == '0) begin
        zp_r <= 1'b1;
      end
      if ((cmd.op == OP_WSET && mov) || (cmd.op == OP_ACC_SUB && (mov || dov)) ||
          (cmd.wr_en && cmd.wr_src == WR_DIV && div_ovf)) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign stat.d_zero   = d_r == '0;
  assign stat.div_done = div_done;
  assign zp_flag       = zp_r;
  assign sat_flag      = sat_r;

endmodule

/* rtl/ldlt_ctrl.sv */
module ldlt_ctrl import ldlt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  ldlt_stat_t        stat,
  output ldlt_cmd_t         cmd,
  output logic              out_strobe,
  output logic [ADDR_W-1:0] out_index,
  output logic              out_last
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_COL   = 4'd1;
  localparam logic [3:0] ST_S1_RA = 4'd2;
  localparam logic [3:0] ST_S1_RB = 4'd3;
  localparam logic [3:0] ST_S1_MU = 4'd4;
  localparam logic [3:0] ST_S1_WR = 4'd5;
  localparam logic [3:0] ST_B_RA  = 4'd6;
  localparam logic [3:0] ST_B_ACC = 4'd7;
  localparam logic [3:0] ST_B_RK  = 4'd8;
  localparam logic [3:0] ST_B_MU  = 4'd9;
  localparam logic [3:0] ST_B_SUB = 4'd10;
  localparam logic [3:0] ST_B_END = 4'd11;
  localparam logic [3:0] ST_DIVW  = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt, i_r, i_nxt, k_r, k_nxt;
  logic [3:0]        size_r, size_nxt;
  logic [5:0]        load_r, load_nxt;
  logic [ADDR_W-1:0] ok_r, ok_nxt;
  logic              outv_r, outv_nxt;
  logic [ADDR_W-1:0] oidx_r, oidx_nxt;
  logic              olast_r, olast_nxt;
  logic [IDX_W-1:0]  n;
  logic [7:0]        tot8;
  logic [5:0]        total;
  logic [5:0]        eff;

  assign n     = (size_r == 4'd0) ? IDX_W'(1) :
                 (size_r > 4'(MAX_ORDER)) ? IDX_W'(MAX_ORDER) : size_r;
  assign tot8  = 8'(({4'b0, n} * ({4'b0, n} + 8'd1)) >> 1);
  assign total = tot8[5:0];
  assign eff   = (load_r >= total) ? 6'd0 : load_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    size_nxt  = size_r;
    load_nxt  = load_r;
    ok_nxt    = ok_r;
    outv_nxt  = 1'b0;
    oidx_nxt  = oidx_r;
    olast_nxt = olast_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_addr  = eff[ADDR_W-1:0];
          cmd.wr_src   = WR_IN;
          cmd.flag_clr = eff == 6'd0;
          if (eff + 6'd1 == total) begin
            load_nxt  = 6'd0;
            j_nxt     = '0;
            state_nxt = ST_COL;
          end else begin
            load_nxt = eff + 6'd1;
          end
        end
        if (cfg_we) begin
          size_nxt = cfg_wdata;
          load_nxt = 6'd0;
        end
      end
      ST_COL: begin
        if (j_r == n) begin
          ok_nxt    = '0;
          state_nxt = ST_EMIT;
        end else if (j_r == '0) begin
          i_nxt     = '0;
          state_nxt = ST_B_RA;
        end else begin
          i_nxt     = '0;
          state_nxt = ST_S1_RA;
        end
      end
      // w(i) = L(j,i) * D(i)
      ST_S1_RA: begin
        cmd.rd_addr = pidx(n, j_r, i_r);
        state_nxt   = ST_S1_RB;
      end
      ST_S1_RB: begin
        cmd.rd_addr = pidx(n, i_r, i_r);
        cmd.op      = OP_LDA;
        state_nxt   = ST_S1_MU;
      end
      ST_S1_MU: begin
        cmd.op    = OP_MUL_RA;
        state_nxt = ST_S1_WR;
      end
      ST_S1_WR: begin
        cmd.op   = OP_WSET;
        cmd.widx = i_r[WIDX_W-1:0];
        if (i_r + 1'b1 == j_r) begin
          i_nxt     = j_r;
          state_nxt = ST_B_RA;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_S1_RA;
        end
      end
      // row i of column j: acc = A(i,j) - sum L(i,k) w(k)
      ST_B_RA: begin
        cmd.rd_addr = pidx(n, i_r, j_r);
        state_nxt   = ST_B_ACC;
      end
      ST_B_ACC: begin
        cmd.op    = OP_ACC_LD;
        k_nxt     = '0;
        state_nxt = (j_r == '0) ? ST_B_END : ST_B_RK;
      end
      ST_B_RK: begin
        cmd.rd_addr = pidx(n, i_r, k_r);
        state_nxt   = ST_B_MU;
      end
      ST_B_MU: begin
        cmd.op    = OP_MUL_RW;
        cmd.widx  = k_r[WIDX_W-1:0];
        state_nxt = ST_B_SUB;
      end
      ST_B_SUB: begin
        cmd.op    = OP_ACC_SUB;
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r + 1'b1 == j_r) ? ST_B_END : ST_B_RK;
      end
      ST_B_END, ST_DIVW: begin
        cmd.wr_addr = pidx(n, i_r, j_r);
        if (state_r == ST_B_END && i_r == j_r) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_ACC;
          cmd.op     = OP_D_LD;
          cmd.zp_set = j_r + 1'b1 < n;
        end else if (state_r == ST_B_END && stat.d_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_ZERO;
        end else if (state_r == ST_B_END) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVW;
        end else if (stat.div_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_DIV;
        end
        if (cmd.wr_en) begin
          if (i_r + 1'b1 == n) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_COL;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_B_RA;
          end
        end
      end
      ST_EMIT: begin
        cmd.rd_addr = ok_r;
        outv_nxt    = 1'b1;
        oidx_nxt    = ok_r;
        olast_nxt   = 6'(ok_r) + 6'd1 == total;
        ok_nxt      = ok_r + 1'b1;
        if (6'(ok_r) + 6'd1 == total) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= 4'(MAX_ORDER);
      load_r  <= '0;
      outv_r  <= 1'b0;
      j_r     <= '0;
      i_r     <= '0;
      k_r     <= '0;
      ok_r    <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      load_r  <= load_nxt;
      outv_r  <= outv_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      ok_r    <= ok_nxt;
    end
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = outv_r;
  assign out_index  = oidx_r;
  assign out_last   = olast_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    outv_r |-> $past(state_r == ST_EMIT))
    else $error("result strobe without a store read");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (load_r < total))
    else $error("load count past the triangle while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIVW && !stat.div_done))
    else $error("divider start not followed by wait");

endmodule
